/* src/intensity_fade_palette_map_top_assert.svh */
// Assertion macros for the intensity fade and palette map block.
// Used by intensity_fade_palette_map_top; needs nothing else.
`ifndef INTENSITY_FADE_PALETTE_MAP_TOP_ASSERT_SVH
`define INTENSITY_FADE_PALETTE_MAP_TOP_ASSERT_SVH

// pre holds at an edge, so post holds at the same edge
`define IFPM_ASSERT_IMP(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("ifpm: same-cycle check failed");

// pre holds at an edge, so post holds at the next edge
`define IFPM_ASSERT_NXT(label, ck, rn, pre, post) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("ifpm: next-cycle check failed");

`endif

/* src/ifpm_pkg.sv */
// Shared types and constants of the intensity fade and palette map block.
// No dependencies; imported by intensity_fade_palette_map_top.
package ifpm_pkg;

    localparam int INT_W          = 15;
    localparam int VOL_W          = 10;
    localparam int COL_W          = 8;
    localparam int PAL_ENTRIES    = 256;
    localparam int PAL_AW         = $clog2(PAL_ENTRIES);
    localparam int FRAC_BITS      = 8;

    localparam int IN_DATA_W      = 64;
    localparam int OUT_DATA_W     = 40;

    // register indexes of the configuration port
    localparam int CFG_AW         = 2;
    localparam logic [CFG_AW-1:0] CFG_TINT_MODE  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TINT_RED   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_TINT_GREEN = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_TINT_BLUE  = 2'd3;

    // item kinds on tuser
    localparam logic OP_PIXEL     = 1'b0;
    localparam logic OP_PAL_WRITE = 1'b1;

    localparam logic [INT_W-1:0] ONE_LEVEL  = INT_W'(1 << FRAC_BITS);
    localparam logic [INT_W-1:0] DARK_LEVEL = INT_W'(20 << FRAC_BITS);
    localparam logic [8:0]       FULL_VOL   = 9'd256;
    localparam logic [15:0]      BLEND_SCALE = 16'd65280;

    // cube index: floor((I^3 * 255) >> 24) compared against 256 * 500000,
    // then (>> 5) and divide by 15625 via an exact reciprocal
    localparam logic [28:0] CUBE_SAT   = 29'(256 * 500000);
    localparam logic [22:0] CUBE_RECIP = 23'(((64'd1 << 36) + 64'd15624) / 64'd15625);

    // blend: floor(num / 65280) = floor((num >> 8) / 255)
    localparam logic [16:0] BLEND_RECIP = 17'(((64'd1 << 24) + 64'd254) / 64'd255);

    typedef logic [3*COL_W-1:0] rgb_t;

endpackage

/* src/intensity_fade_palette_map_top.sv */
// Intensity fade and palette map block: pixel pipeline with palette memory.
// Depends on ifpm_pkg and intensity_fade_palette_map_top_assert.svh.
//
// Usage:
//   s_axis carries items. tuser = op: pixel item or palette write item.
//   A palette write item stores one RGB entry and gives no result; a pixel
//   item gives one result on m_axis: dimmed intensity and an RGB color.
//   The cfg port (cfg_we, cfg_index, cfg_wdata) sets tint mode and the tint
//   color; write it only while no item is in flight.
//   Throughput is one item per clock while m_axis is not stalled. An item
//   passes through the stages in order: two multiplier stages build the cube,
//   one stage scales it, one applies the reciprocal, one reads the palette
//   memory, two form the blend, and the output register holds the result.
//   Palette writes and reads share one memory stage in item order, so a
//   pixel always sees every palette write accepted before it.
//   Reset clears the configuration and marks every palette entry as unwritten;
//   an unwritten entry reads as black, so no clearing pass is needed.
//   When m_axis stalls, the result holds and the stages behind it keep
//   filling empty slots; s_axis_tready drops once no stage is free.
`include "intensity_fade_palette_map_top_assert.svh"

module intensity_fade_palette_map_top
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [ifpm_pkg::CFG_AW-1:0]     cfg_index,
    input  logic [ifpm_pkg::COL_W-1:0]      cfg_wdata,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // intensity[14:0], avg_volume[24:15], palette_index[32:25],
    // palette_red[40:33], palette_green[48:41], palette_blue[56:49], zero pad
    input  logic [ifpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  logic                            s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // faded_intensity[14:0], red[22:15], green[30:23], blue[38:31], zero pad
    output logic [ifpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ifpm_pkg::*;

    // configuration
    logic             tint_mode_reg;
    logic [COL_W-1:0] tint_red_reg;
    logic [COL_W-1:0] tint_green_reg;
    logic [COL_W-1:0] tint_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_mode_reg  <= 1'b0;
            tint_red_reg   <= '0;
            tint_green_reg <= '0;
            tint_blue_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TINT_MODE:  tint_mode_reg  <= cfg_wdata[0];
                CFG_TINT_RED:   tint_red_reg   <= cfg_wdata;
                CFG_TINT_GREEN: tint_green_reg <= cfg_wdata;
                CFG_TINT_BLUE:  tint_blue_reg  <= cfg_wdata;
                default:        tint_mode_reg  <= tint_mode_reg;
            endcase
        end
    end

    // input fields
    logic [INT_W-1:0]  in_int;
    logic [VOL_W-1:0]  in_vol;
    logic [PAL_AW-1:0] in_widx;
    rgb_t              in_wrgb;
    logic [8:0]        in_vol_clamp;
    logic              in_bright;
    logic [INT_W-1:0]  in_faded;

    assign in_int  = s_axis_tdata[14:0];
    assign in_vol  = s_axis_tdata[24:15];
    assign in_widx = s_axis_tdata[32:25];
    assign in_wrgb = s_axis_tdata[56:33];

    assign in_vol_clamp = (in_vol > VOL_W'(FULL_VOL)) ? FULL_VOL : in_vol[8:0];
    assign in_bright    = in_int > DARK_LEVEL;
    assign in_faded     = (tint_mode_reg && !in_bright) ? in_int :
                          (in_int >= ONE_LEVEL) ? (in_int - ONE_LEVEL) : '0;

    // stage valids and ready chain
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg, out_vld_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, out_rdy;

    assign out_rdy = !out_vld_reg || m_axis_tready;
    assign rdy7    = !s7_vld_reg || out_rdy;
    assign rdy6    = !s6_vld_reg || rdy7;
    assign rdy5    = !s5_vld_reg || rdy6;
    assign rdy4    = !s4_vld_reg || rdy5;
    assign rdy3    = !s3_vld_reg || rdy4;
    assign rdy2    = !s2_vld_reg || rdy3;
    assign rdy1    = !s1_vld_reg || rdy2;

    assign s_axis_tready = rdy1;

    // payload registers
    logic              s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg;
    logic [INT_W-1:0]  s1_int_reg;
    logic [29:0]       s1_sq_reg;
    logic [44:0]       s2_cube_reg;
    logic              s3_sat_reg;
    logic [21:0]       s3_x_reg;
    logic [44:0]       s4_prod_reg;
    logic              s4_sat_reg;
    logic [8:0]        s1_vol_reg, s2_vol_reg, s3_vol_reg, s4_vol_reg, s5_vol_reg;
    logic              s1_bright_reg, s2_bright_reg, s3_bright_reg, s4_bright_reg;
    logic              s5_bright_reg, s6_bright_reg, s7_bright_reg;
    logic [INT_W-1:0]  s1_faded_reg, s2_faded_reg, s3_faded_reg, s4_faded_reg;
    logic [INT_W-1:0]  s5_faded_reg, s6_faded_reg, s7_faded_reg;
    logic [PAL_AW-1:0] s1_widx_reg, s2_widx_reg, s3_widx_reg, s4_widx_reg;
    rgb_t              s1_wrgb_reg, s2_wrgb_reg, s3_wrgb_reg, s4_wrgb_reg;
    rgb_t              s5_rgb_reg;
    logic              s5_hit_reg;
    rgb_t              s6_pal_reg, s7_pal_reg;
    logic [16:0]       s6_w_reg;
    logic [15:0]       s7_yr_reg, s7_yg_reg, s7_yb_reg;
    logic [INT_W-1:0]  out_faded_reg;
    rgb_t              out_rgb_reg;

    // valid flow; palette write items leave the pipe at the memory stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)    s1_vld_reg  <= s_axis_tvalid;
            if (rdy2)    s2_vld_reg  <= s1_vld_reg;
            if (rdy3)    s3_vld_reg  <= s2_vld_reg;
            if (rdy4)    s4_vld_reg  <= s3_vld_reg;
            if (rdy5)    s5_vld_reg  <= s4_vld_reg && (s4_op_reg == OP_PIXEL);
            if (rdy6)    s6_vld_reg  <= s5_vld_reg;
            if (rdy7)    s7_vld_reg  <= s6_vld_reg;
            if (out_rdy) out_vld_reg <= s7_vld_reg;
        end
    end

    // stage 1: square
    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            s1_op_reg     <= s_axis_tuser;
            s1_int_reg    <= in_int;
            s1_sq_reg     <= 30'(in_int) * 30'(in_int);
            s1_vol_reg    <= in_vol_clamp;
            s1_bright_reg <= in_bright;
            s1_faded_reg  <= in_faded;
            s1_widx_reg   <= in_widx;
            s1_wrgb_reg   <= in_wrgb;
        end
    end

    // stage 2: cube
    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_vld_reg)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_cube_reg   <= 45'(s1_sq_reg) * 45'(s1_int_reg);
            s2_vol_reg    <= s1_vol_reg;
            s2_bright_reg <= s1_bright_reg;
            s2_faded_reg  <= s1_faded_reg;
            s2_widx_reg   <= s1_widx_reg;
            s2_wrgb_reg   <= s1_wrgb_reg;
        end
    end

    // stage 3: times 255, drop fraction bits, saturate check
    logic [52:0] cube_x255;
    logic [28:0] cube_q1;

    assign cube_x255 = {s2_cube_reg, 8'd0} - {8'd0, s2_cube_reg};
    assign cube_q1   = cube_x255[52:24];

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_vld_reg)
        begin
            s3_op_reg     <= s2_op_reg;
            s3_sat_reg    <= cube_q1 >= CUBE_SAT;
            s3_x_reg      <= cube_q1[26:5];
            s3_vol_reg    <= s2_vol_reg;
            s3_bright_reg <= s2_bright_reg;
            s3_faded_reg  <= s2_faded_reg;
            s3_widx_reg   <= s2_widx_reg;
            s3_wrgb_reg   <= s2_wrgb_reg;
        end
    end

    // stage 4: divide by 15625 through the reciprocal
    always_ff @(posedge clk)
    begin
        if (rdy4 && s3_vld_reg)
        begin
            s4_op_reg     <= s3_op_reg;
            s4_prod_reg   <= 45'(s3_x_reg) * 45'(CUBE_RECIP);
            s4_sat_reg    <= s3_sat_reg;
            s4_vol_reg    <= s3_vol_reg;
            s4_bright_reg <= s3_bright_reg;
            s4_faded_reg  <= s3_faded_reg;
            s4_widx_reg   <= s3_widx_reg;
            s4_wrgb_reg   <= s3_wrgb_reg;
        end
    end

    // stage 5: palette memory, written and read in item order
    rgb_t              pal_mem [PAL_ENTRIES];
    logic [PAL_ENTRIES-1:0] pal_vld_reg;
    logic [PAL_AW-1:0] pal_idx;
    logic              pal_wr;
    logic              pal_rd;

    assign pal_idx = s4_sat_reg ? '1 : s4_prod_reg[36 +: PAL_AW];
    assign pal_wr  = rdy5 && s4_vld_reg && (s4_op_reg == OP_PAL_WRITE);
    assign pal_rd  = rdy5 && s4_vld_reg && (s4_op_reg == OP_PIXEL);

    always_ff @(posedge clk)
    begin
        if (pal_wr)
        begin
            pal_mem[s4_widx_reg] <= s4_wrgb_reg;
        end
        if (pal_rd)
        begin
            s5_rgb_reg    <= pal_mem[pal_idx];
            s5_hit_reg    <= pal_vld_reg[pal_idx];
            s5_vol_reg    <= s4_vol_reg;
            s5_bright_reg <= s4_bright_reg;
            s5_faded_reg  <= s4_faded_reg;
        end
    end

    // mark written entries; unwritten ones read as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_vld_reg <= '0;
        end
        else if (pal_wr)
        begin
            pal_vld_reg[s4_widx_reg] <= 1'b1;
        end
    end

    // stage 6: blend weight from volume and brightest channel
    rgb_t             pal_eff;
    logic [COL_W-1:0] pal_max;

    assign pal_eff = s5_hit_reg ? s5_rgb_reg : '0;

    always_comb
    begin
        pal_max = pal_eff[7:0];
        if (pal_eff[15:8] > pal_max)
        begin
            pal_max = pal_eff[15:8];
        end
        if (pal_eff[23:16] > pal_max)
        begin
            pal_max = pal_eff[23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6 && s5_vld_reg)
        begin
            s6_pal_reg    <= pal_eff;
            s6_w_reg      <= 17'(s5_vol_reg) * 17'(pal_max);
            s6_bright_reg <= s5_bright_reg;
            s6_faded_reg  <= s5_faded_reg;
        end
    end

    // stage 7: blend numerators, already shifted down by 8
    logic [15:0] w_inv;
    logic [24:0] num_r, num_g, num_b;

    assign w_inv = BLEND_SCALE - s6_w_reg[15:0];
    assign num_r = 25'(s6_pal_reg[7:0])   * 25'(w_inv) + 25'(tint_red_reg)   * 25'(s6_w_reg);
    assign num_g = 25'(s6_pal_reg[15:8])  * 25'(w_inv) + 25'(tint_green_reg) * 25'(s6_w_reg);
    assign num_b = 25'(s6_pal_reg[23:16]) * 25'(w_inv) + 25'(tint_blue_reg)  * 25'(s6_w_reg);

    always_ff @(posedge clk)
    begin
        if (rdy7 && s6_vld_reg)
        begin
            s7_yr_reg     <= num_r[23:8];
            s7_yg_reg     <= num_g[23:8];
            s7_yb_reg     <= num_b[23:8];
            s7_pal_reg    <= s6_pal_reg;
            s7_bright_reg <= s6_bright_reg;
            s7_faded_reg  <= s6_faded_reg;
        end
    end

    // output stage: divide by 255 and select the color
    logic [32:0] div_r, div_g, div_b;
    rgb_t        blend_rgb;
    rgb_t        sel_rgb;

    assign div_r     = 33'(s7_yr_reg) * 33'(BLEND_RECIP);
    assign div_g     = 33'(s7_yg_reg) * 33'(BLEND_RECIP);
    assign div_b     = 33'(s7_yb_reg) * 33'(BLEND_RECIP);
    assign blend_rgb = {div_b[31:24], div_g[31:24], div_r[31:24]};
    assign sel_rgb   = !tint_mode_reg ? s7_pal_reg :
                       s7_bright_reg  ? blend_rgb  : '0;

    always_ff @(posedge clk)
    begin
        if (out_rdy && s7_vld_reg)
        begin
            out_faded_reg <= s7_faded_reg;
            out_rgb_reg   <= sel_rgb;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_rgb_reg, out_faded_reg};

    // input stalls only when the whole pipe is full behind a held result
    `IFPM_ASSERT_IMP(a_stall_full, clk, rst_n, !s_axis_tready, out_vld_reg && !m_axis_tready && s7_vld_reg && s1_vld_reg)
    // a pixel in the last stage fills an empty output slot
    `IFPM_ASSERT_NXT(a_out_fill, clk, rst_n, s7_vld_reg && !out_vld_reg, out_vld_reg)
    // a palette write marks its entry as written
    `IFPM_ASSERT_NXT(a_pal_mark, clk, rst_n, pal_wr, pal_vld_reg[$past(s4_widx_reg)])
    // a palette write never reaches the blend stages
    `IFPM_ASSERT_NXT(a_wr_drop, clk, rst_n, pal_wr && !s5_vld_reg, !s5_vld_reg)

endmodule
